/* src/chained_hash_table_resizing_unit_macros.svh */
// Assertion macros for the chained hash table resizing unit.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef CHAINED_HASH_TABLE_RESIZING_UNIT_MACROS_SVH
`define CHAINED_HASH_TABLE_RESIZING_UNIT_MACROS_SVH
`ifndef SYNTH
`define CHR_ASSERT(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) (prop)) \
    else $error("chr assertion failed");
`define CHR_ASSERT_NEXT(lbl, ck, rs, a, b) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |=> (b)) \
    else $error("chr assertion failed");
`else
`define CHR_ASSERT(lbl, ck, rs, prop)
`define CHR_ASSERT_NEXT(lbl, ck, rs, a, b)
`endif
`endif

/* src/chr_pkg.sv */
// Package for the chained hash table resizing unit: payload types, opcodes,
// sequencer states and default sizes. No dependencies.
package chr_pkg;

  localparam int MAX_ENTRIES_DEF = 256;
  localparam int MAX_BUCKETS_DEF = 512;
  localparam int MIN_BUCKETS_DEF = 16;

  localparam logic [1:0] OP_STORE  = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] key;
    logic [63:0] data_in;
  } req_t;

  typedef struct packed {
    logic [63:0] data_out;
    logic        found;
    logic        full_res;
  } rsp_t;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE,
    S_G_HRD, S_G_HD, S_G_ND, S_G_F1, S_G_F2,
    S_S_HRD, S_S_HD, S_S_ND, S_S_H2, S_S_CLR,
    S_F_HRD, S_F_HD, S_F_ND, S_ACT,
    S_ST_ALLOC, S_ST_NEW, S_ST_LINK, S_RM2, S_OUT
  } state_t;

endpackage

/* src/chained_hash_table_resizing_unit.sv */
// Top level of the chained hash table resizing unit: sequencer, counters and
// the bucket and node memories. Depends on chr_pkg, chr_ram and the macros header.
//
//  channel | valid     | stall     | payload         | moves
//  request | req_valid | req_stall | req (req_t)     | store, lookup or remove
//  result  | rsp_valid | rsp_stall | rsp (rsp_t)     | one result per request
//
// One request at a time. A search reads the bucket head, then walks the chain
// node by node; a store then writes or links a node, a remove unlinks it, and
// the result register holds until taken. A grow rehash splits each old
// bucket's chain in two; a shrink appends each upper bucket's chain to its
// lower partner. After reset all bucket heads are cleared before any request.
// req_stall is high whenever a request is in flight or its result waits.
`include "chained_hash_table_resizing_unit_macros.svh"
module chained_hash_table_resizing_unit #(
  parameter int MAX_ENTRIES = chr_pkg::MAX_ENTRIES_DEF,
  parameter int MAX_BUCKETS = chr_pkg::MAX_BUCKETS_DEF,
  parameter int MIN_BUCKETS = chr_pkg::MIN_BUCKETS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  chr_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output chr_pkg::rsp_t rsp
);

  localparam int AW  = $clog2(MAX_ENTRIES);
  localparam int LW  = $clog2(MAX_ENTRIES + 1);
  localparam int CW  = $clog2(MAX_ENTRIES + 1);
  localparam int BAW = $clog2(MAX_BUCKETS);
  localparam int LGW = $clog2(BAW + 1);
  localparam int XW  = CW + BAW + 4;
  localparam logic [LW-1:0]  NIL     = LW'(MAX_ENTRIES);
  localparam logic [LGW-1:0] LOG_MIN = LGW'($clog2(MIN_BUCKETS));

  chr_pkg::state_t state, state_next;

  logic [1:0]     op;
  logic [63:0]    key, val;
  logic [CW-1:0]  cnt;
  logic [LGW-1:0] log;
  logic [LW-1:0]  free_head;
  logic [CW-1:0]  fresh;
  logic [BAW-1:0] idx;
  logic [LW-1:0]  cur, prev, lo_h, lo_t, hi_h, hi_t, slot, fnd_next;
  logic [63:0]    fnd_val;
  logic           hit;
  chr_pkg::rsp_t  rsp_r;

  logic            h_we, x_we, kv_we, v_we_s;
  logic [BAW-1:0]  h_waddr, h_raddr;
  logic [LW-1:0]   h_wdata, h_rdata, x_wdata, x_rdata;
  logic [AW-1:0]   x_waddr, n_raddr, kv_waddr;
  logic [63:0]     k_rdata, v_rdata, v_wdata;

  logic [BAW:0]    bc;
  logic [BAW-1:0]  half, old_b, bkt;
  logic [63:0]     ksh;
  logic            grow, shrink, hb;

  chr_ram #(.W(LW), .D(MAX_BUCKETS)) u_head (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rdata));
  chr_ram #(.W(64), .D(MAX_ENTRIES)) u_key (
    .clk(clk), .we(kv_we), .waddr(kv_waddr), .wdata(key),
    .raddr(n_raddr), .rdata(k_rdata));
  chr_ram #(.W(64), .D(MAX_ENTRIES)) u_val (
    .clk(clk), .we(kv_we || v_we_s), .waddr(kv_waddr), .wdata(v_wdata),
    .raddr(n_raddr), .rdata(v_rdata));
  chr_ram #(.W(LW), .D(MAX_ENTRIES)) u_next (
    .clk(clk), .we(x_we), .waddr(x_waddr), .wdata(x_wdata),
    .raddr(n_raddr), .rdata(x_rdata));

  function automatic logic ok(input logic [LW-1:0] l);
    ok = (l < NIL);
  endfunction

  assign bc     = (BAW+1)'(1) << log;
  assign half   = bc[BAW:1];
  assign old_b  = bc[BAW-1:0];
  assign bkt    = key[2 +: BAW] & BAW'(bc - 1'b1);
  assign ksh    = k_rdata >> (7'(log) + 7'd2);
  assign hb     = ksh[0];
  assign grow   = (XW'(cnt) * 4 >= XW'(bc) * 3) && (XW'(bc) * 2 <= XW'(MAX_BUCKETS));
  assign shrink = (XW'(cnt) * 10 < XW'(bc) * 3) && (XW'(half) >= XW'(MIN_BUCKETS))
                  && (log != '0);

  assign req_stall = (state != chr_pkg::S_IDLE);
  assign rsp_valid = (state == chr_pkg::S_OUT);
  assign rsp       = rsp_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= chr_pkg::S_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    h_we = 1'b0; h_waddr = idx; h_wdata = NIL; h_raddr = idx;
    x_we = 1'b0; x_waddr = cur[AW-1:0]; x_wdata = NIL;
    kv_we = 1'b0; kv_waddr = slot[AW-1:0]; v_we_s = 1'b0; v_wdata = val;
    n_raddr = cur[AW-1:0];
    case (state)
      chr_pkg::S_CLR: begin
        h_we = 1'b1;
        if (idx == BAW'(MAX_BUCKETS - 1)) state_next = chr_pkg::S_IDLE;
      end
      chr_pkg::S_IDLE: begin
        if (req_valid) begin
          if (req.opcode == chr_pkg::OP_STORE && grow) state_next = chr_pkg::S_G_HRD;
          else if (req.opcode == chr_pkg::OP_REMOVE && shrink) state_next = chr_pkg::S_S_HRD;
          else state_next = chr_pkg::S_F_HRD;
        end
      end
      chr_pkg::S_G_HRD: state_next = chr_pkg::S_G_HD;
      chr_pkg::S_G_HD: begin
        n_raddr = h_rdata[AW-1:0];
        state_next = ok(h_rdata) ? chr_pkg::S_G_ND : chr_pkg::S_G_F1;
      end
      chr_pkg::S_G_ND: begin
        if (hb) begin
          x_we = ok(hi_t); x_waddr = hi_t[AW-1:0];
        end else begin
          x_we = ok(lo_t); x_waddr = lo_t[AW-1:0];
        end
        x_wdata = cur;
        n_raddr = x_rdata[AW-1:0];
        if (!ok(x_rdata)) state_next = chr_pkg::S_G_F1;
      end
      chr_pkg::S_G_F1: begin
        x_we = ok(lo_t); x_waddr = lo_t[AW-1:0];
        h_we = 1'b1; h_wdata = lo_h;
        state_next = chr_pkg::S_G_F2;
      end
      chr_pkg::S_G_F2: begin
        x_we = ok(hi_t); x_waddr = hi_t[AW-1:0];
        h_we = 1'b1; h_waddr = idx + old_b; h_wdata = hi_h;
        state_next = (idx == BAW'(bc - 1'b1)) ? chr_pkg::S_F_HRD : chr_pkg::S_G_HRD;
      end
      chr_pkg::S_S_HRD: state_next = chr_pkg::S_S_HD;
      chr_pkg::S_S_HD: begin
        n_raddr = h_rdata[AW-1:0];
        h_raddr = idx + half;
        state_next = ok(h_rdata) ? chr_pkg::S_S_ND : chr_pkg::S_S_H2;
      end
      chr_pkg::S_S_ND: begin
        n_raddr = x_rdata[AW-1:0];
        h_raddr = idx + half;
        if (!ok(x_rdata)) state_next = chr_pkg::S_S_H2;
      end
      chr_pkg::S_S_H2: begin
        if (ok(lo_t)) begin
          x_we = 1'b1; x_waddr = lo_t[AW-1:0]; x_wdata = h_rdata;
        end else begin
          h_we = 1'b1; h_wdata = h_rdata;
        end
        state_next = chr_pkg::S_S_CLR;
      end
      chr_pkg::S_S_CLR: begin
        h_we = 1'b1; h_waddr = idx + half;
        state_next = (idx == half - 1'b1) ? chr_pkg::S_F_HRD : chr_pkg::S_S_HRD;
      end
      chr_pkg::S_F_HRD: begin
        h_raddr = bkt;
        state_next = chr_pkg::S_F_HD;
      end
      chr_pkg::S_F_HD: begin
        n_raddr = h_rdata[AW-1:0];
        state_next = ok(h_rdata) ? chr_pkg::S_F_ND : chr_pkg::S_ACT;
      end
      chr_pkg::S_F_ND: begin
        n_raddr = x_rdata[AW-1:0];
        if (k_rdata == key || !ok(x_rdata)) state_next = chr_pkg::S_ACT;
      end
      chr_pkg::S_ACT: begin
        state_next = chr_pkg::S_OUT;
        n_raddr = free_head[AW-1:0];
        if (op == chr_pkg::OP_STORE) begin
          if (hit) begin
            v_we_s = 1'b1; kv_waddr = cur[AW-1:0];
          end else if (ok(free_head)) begin
            state_next = chr_pkg::S_ST_ALLOC;
          end else if (fresh < CW'(MAX_ENTRIES)) begin
            state_next = chr_pkg::S_ST_NEW;
          end
        end else if (op == chr_pkg::OP_REMOVE && hit) begin
          if (ok(prev)) begin
            x_we = 1'b1; x_waddr = prev[AW-1:0]; x_wdata = fnd_next;
          end else begin
            h_we = 1'b1; h_waddr = bkt; h_wdata = fnd_next;
          end
          state_next = chr_pkg::S_RM2;
        end
      end
      chr_pkg::S_ST_ALLOC: state_next = chr_pkg::S_ST_NEW;
      chr_pkg::S_ST_NEW: begin
        kv_we = 1'b1;
        x_we = 1'b1; x_waddr = slot[AW-1:0];
        if (!ok(prev)) begin
          h_we = 1'b1; h_waddr = bkt; h_wdata = slot;
        end
        state_next = ok(prev) ? chr_pkg::S_ST_LINK : chr_pkg::S_OUT;
      end
      chr_pkg::S_ST_LINK: begin
        x_we = 1'b1; x_waddr = prev[AW-1:0]; x_wdata = slot;
        state_next = chr_pkg::S_OUT;
      end
      chr_pkg::S_RM2: begin
        x_we = 1'b1; x_wdata = free_head;
        state_next = chr_pkg::S_OUT;
      end
      chr_pkg::S_OUT: begin
        if (!rsp_stall) state_next = chr_pkg::S_IDLE;
      end
      default: state_next = chr_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      cnt       <= '0;
      log       <= LOG_MIN;
      free_head <= NIL;
      fresh     <= '0;
    end else begin
      case (state)
        chr_pkg::S_CLR: idx <= idx + 1'b1;
        chr_pkg::S_IDLE: begin
          if (req_valid) begin
            op  <= req.opcode;
            key <= req.key;
            val <= req.data_in;
            idx <= '0;
          end
        end
        chr_pkg::S_G_HRD: begin
          lo_h <= NIL; lo_t <= NIL; hi_h <= NIL; hi_t <= NIL;
        end
        chr_pkg::S_G_HD: cur <= h_rdata;
        chr_pkg::S_G_ND: begin
          if (hb) begin
            if (!ok(hi_t)) hi_h <= cur;
            hi_t <= cur;
          end else begin
            if (!ok(lo_t)) lo_h <= cur;
            lo_t <= cur;
          end
          cur <= x_rdata;
        end
        chr_pkg::S_G_F2: begin
          idx <= idx + 1'b1;
          if (idx == BAW'(bc - 1'b1)) log <= log + 1'b1;
        end
        chr_pkg::S_S_HRD: lo_t <= NIL;
        chr_pkg::S_S_HD: cur <= h_rdata;
        chr_pkg::S_S_ND: begin
          lo_t <= cur;
          cur  <= x_rdata;
        end
        chr_pkg::S_S_CLR: begin
          idx <= idx + 1'b1;
          if (idx == half - 1'b1) log <= log - 1'b1;
        end
        chr_pkg::S_F_HRD: begin
          prev <= NIL;
          hit  <= 1'b0;
        end
        chr_pkg::S_F_HD: cur <= h_rdata;
        chr_pkg::S_F_ND: begin
          if (k_rdata == key) begin
            hit      <= 1'b1;
            fnd_val  <= v_rdata;
            fnd_next <= x_rdata;
          end else begin
            prev <= cur;
            cur  <= x_rdata;
          end
        end
        chr_pkg::S_ACT: begin
          if (op == chr_pkg::OP_STORE) begin
            if (hit) begin
              rsp_r <= '{data_out: val, found: 1'b1, full_res: 1'b0};
            end else if (ok(free_head)) begin
              slot <= free_head;
            end else if (fresh < CW'(MAX_ENTRIES)) begin
              slot  <= LW'(fresh);
              fresh <= fresh + 1'b1;
            end else begin
              rsp_r <= '{data_out: 64'd0, found: 1'b0, full_res: 1'b1};
            end
          end else if (hit) begin
            rsp_r <= '{data_out: fnd_val, found: 1'b1, full_res: 1'b0};
          end else begin
            rsp_r <= '{data_out: 64'd0, found: 1'b0, full_res: 1'b0};
          end
        end
        chr_pkg::S_ST_ALLOC: free_head <= x_rdata;
        chr_pkg::S_ST_NEW: begin
          cnt   <= cnt + 1'b1;
          rsp_r <= '{data_out: val, found: 1'b0, full_res: 1'b0};
        end
        chr_pkg::S_RM2: begin
          free_head <= cur;
          if (cnt != '0) cnt <= cnt - 1'b1;
        end
        default: ;
      endcase
    end
  end

  `CHR_ASSERT_NEXT(a_busy_after_accept, clk, rst, req_valid && !req_stall, req_stall)
  `CHR_ASSERT(a_full_not_found, clk, rst, !(rsp_valid && rsp.full_res && rsp.found))
  `CHR_ASSERT(a_count_bound, clk, rst, cnt <= CW'(MAX_ENTRIES))
  `CHR_ASSERT(a_fresh_bound, clk, rst, fresh <= CW'(MAX_ENTRIES))
  `CHR_ASSERT(a_log_range, clk, rst, log >= LOG_MIN && log <= LGW'(BAW))

endmodule

/* src/chr_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module chr_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* dv/tb_chained_hash_table_resizing_unit.sv */
// Testbench for the chained hash table resizing unit: a local hash map model
// predicts each result; a scoreboard class checks results in order.
// Depends on chr_pkg and the chained_hash_table_resizing_unit RTL.
module tb_chained_hash_table_resizing_unit;

  localparam int NENT = 256;
  localparam int NBKT = 512;
  localparam int MINB = 16;
  localparam logic [8:0] NIL = 9'(NENT);

  class map_scoreboard;
    logic [8:0]  head [NBKT];
    logic [63:0] nkey [NENT];
    logic [63:0] nval [NENT];
    logic [8:0]  nnext [NENT];
    int unsigned entries, blog, fresh;
    logic [8:0]  free_list;
    chr_pkg::rsp_t pending [$];
    int          errors;

    function void clear();
      foreach (head[i]) head[i] = NIL;
      foreach (nnext[i]) begin
        nnext[i] = NIL; nkey[i] = '0; nval[i] = '0;
      end
      entries = 0; blog = 4; fresh = 0; free_list = NIL; errors = 0;
    endfunction

    function int unsigned bucket(logic [63:0] k, int unsigned lg);
      return k[33:2] & ((32'd1 << lg) - 1);
    endfunction

    function void rebuild(int unsigned new_log);
      logic [8:0] th [NBKT];
      logic [8:0] tt [NBKT];
      logic [8:0] n, nx;
      int unsigned b;
      foreach (th[i]) begin th[i] = NIL; tt[i] = NIL; end
      for (int i = 0; i < (1 << blog); i++) begin
        n = head[i];
        while (n != NIL) begin
          nx = nnext[n];
          b = bucket(nkey[n], new_log);
          nnext[n] = NIL;
          if (tt[b] == NIL) th[b] = n; else nnext[tt[b]] = n;
          tt[b] = n;
          n = nx;
        end
      end
      foreach (head[i]) head[i] = (i < (1 << new_log)) ? th[i] : NIL;
      blog = new_log;
    endfunction

    function logic [8:0] find(logic [63:0] k, output logic [8:0] prev);
      logic [8:0] n;
      n = head[bucket(k, blog)];
      prev = NIL;
      while (n != NIL && nkey[n] != k) begin prev = n; n = nnext[n]; end
      return n;
    endfunction

    function void note_request(chr_pkg::req_t r);
      chr_pkg::rsp_t e;
      logic [8:0] n, prev, slot;
      int unsigned cnt;
      e = '0;
      cnt = 1 << blog;
      if (r.opcode == chr_pkg::OP_STORE) begin
        if (entries * 4 >= cnt * 3 && cnt * 2 <= NBKT) rebuild(blog + 1);
        n = find(r.key, prev);
        if (n != NIL) begin
          nval[n] = r.data_in; e.data_out = r.data_in; e.found = 1;
        end else begin
          slot = NIL;
          if (free_list != NIL) begin
            slot = free_list; free_list = nnext[slot];
          end else if (fresh < NENT) begin
            slot = 9'(fresh); fresh++;
          end
          if (slot == NIL) e.full_res = 1;
          else begin
            nkey[slot] = r.key; nval[slot] = r.data_in; nnext[slot] = NIL;
            if (prev != NIL) nnext[prev] = slot;
            else head[bucket(r.key, blog)] = slot;
            entries++;
            e.data_out = r.data_in;
          end
        end
      end else if (r.opcode == chr_pkg::OP_REMOVE) begin
        if (entries * 10 < cnt * 3 && (cnt >> 1) >= MINB) rebuild(blog - 1);
        n = find(r.key, prev);
        if (n != NIL) begin
          e.data_out = nval[n]; e.found = 1;
          if (prev != NIL) nnext[prev] = nnext[n];
          else head[bucket(r.key, blog)] = nnext[n];
          nnext[n] = free_list; free_list = n;
          if (entries > 0) entries--;
        end
      end else begin
        n = find(r.key, prev);
        if (n != NIL) begin e.data_out = nval[n]; e.found = 1; end
      end
      pending.push_back(e);
    endfunction

    function void check_result(chr_pkg::rsp_t got);
      chr_pkg::rsp_t e;
      if (pending.size() == 0) begin
        $error("result with no expectation: %h", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.data_out !== e.data_out) begin
        $error("data_out exp %h got %h", e.data_out, got.data_out); errors++;
      end
      if (got.found !== e.found) begin
        $error("found exp %b got %b", e.found, got.found); errors++;
      end
      if (got.full_res !== e.full_res) begin
        $error("full_res exp %b got %b", e.full_res, got.full_res); errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic req_valid, req_stall, rsp_valid, rsp_stall;
  chr_pkg::req_t req;
  chr_pkg::rsp_t rsp;
  map_scoreboard sb;
  logic [63:0] key_pool [64];
  int cycles;
  bit hold_off;

  chained_hash_table_resizing_unit u_top (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  task automatic send(logic [1:0] op, logic [63:0] k, logic [63:0] d);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      req_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1;
    req <= '{opcode: op, key: k, data_in: d};
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.note_request(chr_pkg::req_t'{opcode: op, key: k, data_in: d});
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_key(int span);
    return key_pool[$urandom_range(0, span - 1)];
  endfunction

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check_result(rsp);
  end

  initial begin : receiver
    int w;
    rsp_stall = 1;
    @(negedge rst);
    forever begin
      if (hold_off) begin
        rsp_stall <= 1;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      if (w != 0) begin
        rsp_stall <= 1;
        repeat (w) @(posedge clk);
      end
      rsp_stall <= 0;
      @(posedge clk);
      while (!rsp_valid) @(posedge clk);
    end
  end

  initial begin : watchdog
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 2000000) begin
        $display("tb_chained_hash_table_resizing_unit: errors");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [1:0] op;
    int span;
    sb = new();
    sb.clear();
    rst = 1; req_valid = 0; req = '0;
    hold_off = 0;
    foreach (key_pool[i]) key_pool[i] = rand64();
    key_pool[0] = '0;
    key_pool[1] = '1;
    key_pool[2] = 64'h0000_0000_0000_0040;
    key_pool[3] = 64'h0000_0001_0000_0040;
    key_pool[4] = 64'h8000_0000_0000_0040;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: extremes, every opcode incl. 3, collisions, absent keys
    send(chr_pkg::OP_LOOKUP, '0, '1);
    send(chr_pkg::OP_REMOVE, '1, '0);
    send(chr_pkg::OP_STORE, '0, '1);
    send(chr_pkg::OP_STORE, '1, '0);
    send(chr_pkg::OP_STORE, key_pool[2], 64'h1);
    send(chr_pkg::OP_STORE, key_pool[3], 64'h2);
    send(chr_pkg::OP_STORE, key_pool[4], 64'h3);
    send(chr_pkg::OP_STORE, key_pool[3], 64'hAAAA_5555_AAAA_5555);
    send(chr_pkg::OP_LOOKUP, key_pool[3], '0);
    send(2'd3, key_pool[4], '1);
    send(2'd3, 64'h1234, '0);
    send(chr_pkg::OP_REMOVE, key_pool[3], '0);
    send(chr_pkg::OP_LOOKUP, key_pool[4], '0);
    send(chr_pkg::OP_REMOVE, key_pool[2], '0);
    send(chr_pkg::OP_STORE, key_pool[3], 64'h5555_AAAA_5555_AAAA);
    send(chr_pkg::OP_REMOVE, '0, '0);
    send(chr_pkg::OP_LOOKUP, '1, '0);
    hold_off = 1;
    // random: phases of growth toward the pool limit, mixed traffic and drain
    for (int i = 0; i < 750; i++) begin
      if (i < 300) begin
        op = ($urandom_range(0, 9) < 8) ? chr_pkg::OP_STORE : chr_pkg::OP_LOOKUP;
        send(op, rand64(), rand64());
      end else if (i < 550) begin
        span = 64;
        op = 2'($urandom_range(0, 3));
        send(op, ($urandom_range(0, 4) == 0) ? rand64() : pick_key(span), rand64());
      end else begin
        op = ($urandom_range(0, 5) == 0) ? chr_pkg::OP_LOOKUP : chr_pkg::OP_REMOVE;
        send(op, ($urandom_range(0, 1) == 0) ? pick_key(64) : rand64(), '0);
        if (i == 600) hold_off = 1;
      end
      if (i == 200) hold_off = 1;
    end
    req_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("tb_chained_hash_table_resizing_unit: clean");
    else
      $display("tb_chained_hash_table_resizing_unit: errors");
    $finish;
  end
endmodule
